// File: hw/rtl/rtc_millisecond_timestamp_assert.svh
// assertion macros for the millisecond timestamp block
`ifndef RTC_MILLISECOND_TIMESTAMP_ASSERT_SVH
`define RTC_MILLISECOND_TIMESTAMP_ASSERT_SVH
`ifndef SYNTHESIS
`define RTC_MS_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("rtc_ms: same-cycle check failed");
`define RTC_MS_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("rtc_ms: next-cycle check failed");
`else
`define RTC_MS_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS)
`define RTC_MS_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS)
`endif
`endif

// File: hw/rtl/rtc_ms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtc_ms_pkg;

    localparam int MS_W          = 32;
    localparam int KIND_W        = 2;
    localparam int PRESCALE_BITS = 15;
    localparam int MS_PER_SEC    = 1000;

    // remainder of a division by 1000 fits in 10 bits
    localparam int REM_W = 10;

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam int                     DIV_MAGIC_W = 29;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC   = 29'd274877907;
    localparam int                     DIV_SHIFT   = 38;
    localparam int                     QUO_W       = MS_W + DIV_MAGIC_W - DIV_SHIFT;

    localparam logic [MS_W-1:0]          ALL_ONES  = {MS_W{1'b1}};
    localparam logic [REM_W-1:0]         REM_STEP  = REM_W'(MS_PER_SEC);
    localparam logic [PRESCALE_BITS-1:0] ACC_STEP  = PRESCALE_BITS'(MS_PER_SEC);

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [MS_W-1:0]   ms;
    } rtc_ms_item_t;

    typedef struct packed {
        logic              adv;
        logic              exec_valid;
        logic [KIND_W-1:0] exec_kind;
        logic [MS_W-1:0]   now_ms;
        logic [MS_W-1:0]   last_ms;
    } rtc_ms_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtc_ms_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtc_ms_req_if;
    logic                          valid;
    logic                          ready;
    logic [rtc_ms_pkg::KIND_W-1:0] kind;
    logic [rtc_ms_pkg::MS_W-1:0]   set_ms;

    modport source (output valid, output kind, output set_ms, input ready);
    modport sink   (input valid, input kind, input set_ms, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rtc_ms_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtc_ms_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rtc_ms_pkg::MS_W-1:0] timestamp_ms;

    modport source (output valid, output timestamp_ms, input ready);
    modport sink   (input valid, input timestamp_ms, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rtc_ms_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_ms_conv (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    rtc_ms_req_if.sink                                 req,
    output rtc_ms_pkg::rtc_ms_item_t                   exec_item,
    output logic [rtc_ms_pkg::PRESCALE_BITS-1:0]       prescale_pos
);

    localparam int PB     = rtc_ms_pkg::PRESCALE_BITS;
    localparam int MW     = rtc_ms_pkg::MS_W;
    localparam int RW     = rtc_ms_pkg::REM_W;
    localparam int KW     = rtc_ms_pkg::DIV_MAGIC_W;
    localparam int QW     = rtc_ms_pkg::QUO_W;
    localparam int XW     = RW + PB;

    rtc_ms_pkg::rtc_ms_item_t s0_reg, s1_reg, s2_reg, s3_reg;
    rtc_ms_pkg::rtc_ms_item_t s0_next;

    logic [QW-1:0] q_reg, q_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [PB-1:0] pos_reg, pos_next;

    logic [MW+KW-1:0] quo_prod;
    logic [RW-1:0]    q_low_k;
    logic [XW-1:0]    scaled_rem;
    logic [XW+KW-1:0] pos_prod;

    assign req.ready = adv;

    assign s0_next.valid = req.valid;
    assign s0_next.kind  = req.kind;
    assign s0_next.ms    = req.set_ms;

    // seconds = set_ms / 1000
    assign quo_prod = {{KW{1'b0}}, s0_reg.ms} * {{MW{1'b0}}, rtc_ms_pkg::DIV_MAGIC};
    assign q_next   = quo_prod[rtc_ms_pkg::DIV_SHIFT +: QW];

    // remainder needs only the low bits
    assign q_low_k  = q_reg[RW-1:0] * rtc_ms_pkg::REM_STEP;
    assign rem_next = s1_reg.ms[RW-1:0] - q_low_k;

    // prescaler position = floor(rem * 2^PB / 1000)
    assign scaled_rem = {rem_reg, {PB{1'b0}}};
    assign pos_prod   = {{KW{1'b0}}, scaled_rem} * {{XW{1'b0}}, rtc_ms_pkg::DIV_MAGIC};
    assign pos_next   = pos_prod[rtc_ms_pkg::DIV_SHIFT +: PB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s0_reg <= s0_next;
            s1_reg <= s0_reg;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
    end

    assign exec_item    = s3_reg;
    assign prescale_pos = pos_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rtc_ms_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_ms_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire rtc_ms_pkg::rtc_ms_item_t              exec_item,
    input  wire logic [rtc_ms_pkg::PRESCALE_BITS-1:0]  prescale_pos,
    rtc_ms_rsp_if.source                               rsp,
    output rtc_ms_pkg::rtc_ms_status_t                 status
);

    localparam int PB = rtc_ms_pkg::PRESCALE_BITS;
    localparam int MW = rtc_ms_pkg::MS_W;

    // now_ms tracks seconds*1000 + floor(prescaler*1000/2^PB)
    // acc holds prescaler*1000 mod 2^PB, its carry moves now_ms
    logic [MW-1:0] now_reg, now_next;
    logic [PB-1:0] acc_reg, acc_next;
    logic [MW-1:0] last_reg, last_next;
    logic          rv_reg, rv_next;
    logic [MW-1:0] data_reg, data_next;

    logic [PB:0]   tick_sum;
    logic [PB-1:0] set_acc;
    logic          set_frac_low;
    logic [MW-1:0] read_ms;

    assign tick_sum = {1'b0, acc_reg} + {1'b0, rtc_ms_pkg::ACC_STEP};
    assign set_acc  = prescale_pos * rtc_ms_pkg::ACC_STEP;
    // a nonzero acc after a set leaves now_ms one below set_ms
    assign set_frac_low = (set_acc != '0);
    assign read_ms  = (now_reg < last_reg && last_reg != rtc_ms_pkg::ALL_ONES)
                      ? last_reg : now_reg;

    always_comb
    begin
        now_next  = now_reg;
        acc_next  = acc_reg;
        last_next = last_reg;
        rv_next   = rv_reg;
        data_next = data_reg;
        if (adv)
        begin
            rv_next = 1'b0;
            if (exec_item.valid)
            begin
                case (exec_item.kind)
                    rtc_ms_pkg::KIND_TICK:
                    begin
                        acc_next = tick_sum[PB-1:0];
                        now_next = now_reg + {{(MW-1){1'b0}}, tick_sum[PB]};
                    end
                    rtc_ms_pkg::KIND_SET:
                    begin
                        now_next  = exec_item.ms - {{(MW-1){1'b0}}, set_frac_low};
                        acc_next  = set_acc;
                        last_next = exec_item.ms;
                    end
                    rtc_ms_pkg::KIND_READ:
                    begin
                        last_next = read_ms;
                        rv_next   = 1'b1;
                        data_next = read_ms;
                    end
                    rtc_ms_pkg::KIND_CLEAR:
                    begin
                        now_next  = '0;
                        acc_next  = '0;
                        last_next = '0;
                    end
                    default:
                    begin
                        now_next = now_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg  <= '0;
            acc_reg  <= '0;
            last_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            now_reg  <= now_next;
            acc_reg  <= acc_next;
            last_reg <= last_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rsp.valid        = rv_reg;
    assign rsp.timestamp_ms = data_reg;

    assign status.adv        = adv;
    assign status.exec_valid = exec_item.valid;
    assign status.exec_kind  = exec_item.kind;
    assign status.now_ms     = now_reg;
    assign status.last_ms    = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rtc_millisecond_timestamp.sv
// Millisecond real-time clock. Each req transaction is a tick of the 2^15 Hz
// oscillator, a set of the time in milliseconds, a read or a clear; only a
// read gives a rsp transaction, whose timestamp never goes backwards unless
// the clock is set or cleared, or the last reported value was all ones. One
// transaction is taken every cycle unless the pipeline holds (see below): a
// set passes through three multiply stages (seconds, remainder, prescaler
// position) before it reaches the counters, and every kind follows the same
// path so order is kept. req.ready is low only while a result waits in the
// output register and rsp.ready is low; then the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

`include "rtc_millisecond_timestamp_assert.svh"

module rtc_millisecond_timestamp (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rtc_ms_req_if.sink   req,
    rtc_ms_rsp_if.source rsp
);

    logic                                   adv;
    rtc_ms_pkg::rtc_ms_item_t               exec_item;
    logic [rtc_ms_pkg::PRESCALE_BITS-1:0]   prescale_pos;
    rtc_ms_pkg::rtc_ms_status_t             status;

    logic                                   read_fires;
    logic                                   tick_fires;
    logic                                   rsp_stalled;
    logic                                   rsp_is_last;
    logic [rtc_ms_pkg::MS_W-1:0]            now_ms;

    assign adv = !(rsp.valid && !rsp.ready);

    rtc_ms_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .req          (req),
        .exec_item    (exec_item),
        .prescale_pos (prescale_pos)
    );

    rtc_ms_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .exec_item    (exec_item),
        .prescale_pos (prescale_pos),
        .rsp          (rsp),
        .status       (status)
    );

    assign read_fires  = status.adv && status.exec_valid
                         && status.exec_kind == rtc_ms_pkg::KIND_READ;
    assign tick_fires  = status.adv && status.exec_valid
                         && status.exec_kind == rtc_ms_pkg::KIND_TICK;
    assign rsp_stalled = rsp.valid && !rsp.ready;
    assign rsp_is_last = rsp.valid && rsp.timestamp_ms == status.last_ms;
    assign now_ms      = status.now_ms;

    `RTC_MS_ASSERT_NEXT(a_read_matches_last, clk, rst_n, read_fires, rsp_is_last)
    `RTC_MS_ASSERT_NOW(a_stall_only_on_backpressure, clk, rst_n, !req.ready, rsp_stalled)
    `RTC_MS_ASSERT_NEXT(a_tick_step_small, clk, rst_n, tick_fires, now_ms - $past(now_ms) <= 32'd1)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rtc_ms_pkg::*;

    localparam int    RANDOM_ITEMS = 1500;
    localparam int    QUIET_TAIL   = 200;
    localparam int    SCRIPT_LEN   = 25;
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MS_W-1:0]   ms;
        logic [15:0]       reps;
        logic              typed;
        logic [MS_W-1:0]   want;
    } script_row_t;

    logic clk;
    logic rst_n;

    rtc_ms_req_if req_bus();
    rtc_ms_rsp_if rsp_bus();

    rtc_millisecond_timestamp uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // predicted clock state
    logic [PRESCALE_BITS-1:0] presc_q;
    logic [MS_W-1:0]          sec_q;
    logic [MS_W-1:0]          last_ms_q;

    logic [MS_W-1:0] expected_ts [$];
    int              error_count;
    longint          cycle_count;
    int              items_sent;
    bit              idle_on;
    script_row_t     script [SCRIPT_LEN];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [MS_W-1:0] got,
                                   input logic [MS_W-1:0] want);
        $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic predict_rtc(input logic [KIND_W-1:0] kind, input logic [MS_W-1:0] ms,
                               output bit has_ts, output logic [MS_W-1:0] ts);
        logic [63:0] rem;
        logic [63:0] now64;
        logic [MS_W-1:0] now;
        has_ts = 1'b0;
        ts     = '0;
        case (kind)
            KIND_TICK:
            begin
                presc_q = presc_q + 1'b1;
                if (presc_q == '0)
                    sec_q = sec_q + 1'b1;
            end
            KIND_SET:
            begin
                rem       = 64'(ms % MS_PER_SEC);
                presc_q   = PRESCALE_BITS'((rem << PRESCALE_BITS) / MS_PER_SEC);
                sec_q     = ms / MS_PER_SEC;
                last_ms_q = ms;
            end
            KIND_READ:
            begin
                now64 = 64'(sec_q) * MS_PER_SEC
                      + ((64'(presc_q) * MS_PER_SEC) >> PRESCALE_BITS);
                now    = now64[MS_W-1:0];
                has_ts = 1'b1;
                // held back unless the last value is the stuck all-ones pattern
                if (now < last_ms_q && last_ms_q != ALL_ONES)
                    ts = last_ms_q;
                else
                begin
                    last_ms_q = now;
                    ts        = now;
                end
            end
            default:
            begin
                presc_q   = '0;
                sec_q     = '0;
                last_ms_q = '0;
            end
        endcase
    endtask

    task automatic send_txn(input logic [KIND_W-1:0] kind, input logic [MS_W-1:0] ms,
                            input bit typed, input logic [MS_W-1:0] want);
        bit              has_ts;
        logic [MS_W-1:0] ts;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.kind   <= kind;
        req_bus.set_ms <= ms;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        predict_rtc(kind, ms, has_ts, ts);
        if (has_ts)
            expected_ts.push_back(typed ? want : ts);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic read_burst(input int ticks);
        repeat (ticks) send_txn(KIND_TICK, $urandom(), 1'b0, '0);
        send_txn(KIND_READ, $urandom(), 1'b0, '0);
    endtask

    // result side: stall in bursts while idling is on
    initial
    begin
        int stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (expected_ts.size() == 0)
                report_mismatch("unexpected read transaction", rsp_bus.timestamp_ms, '0);
            else if (rsp_bus.timestamp_ms !== expected_ts[0])
            begin
                report_mismatch("timestamp_ms", rsp_bus.timestamp_ms, expected_ts[0]);
                void'(expected_ts.pop_front());
            end
            else
                void'(expected_ts.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int              start_count;
        logic [MS_W-1:0] ms;
        error_count    = 0;
        cycle_count    = 0;
        items_sent     = 0;
        idle_on        = 1'b1;
        presc_q        = '0;
        sec_q          = '0;
        last_ms_q      = '0;
        rst_n          = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.kind   = KIND_TICK;
        req_bus.set_ms = '0;

        script = '{
            // reads after reset
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd0},
            '{KIND_TICK,  32'h0000_0000, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd0},
            // all-ones set never holds a read back
            '{KIND_SET,   32'hFFFF_FFFF, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'hFFFF_FFFE},
            // millisecond value climbs to all ones
            '{KIND_TICK,  32'h0000_0000, 16'd9,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'hFFFF_FFFF},
            // a read equal to the last value is reported as is
            '{KIND_SET,   32'd2,         16'd1,     1'b0, 32'd0},
            '{KIND_TICK,  32'h0000_0000, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd2},
            // rounding after a set falls below the set value
            '{KIND_SET,   32'd1,         16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd1},
            // prescaler wraps into the seconds counter
            '{KIND_SET,   32'd999,       16'd1,     1'b0, 32'd0},
            '{KIND_TICK,  32'h0000_0000, 16'd32,    1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b0, 32'd0},
            '{KIND_TICK,  32'h0000_0000, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd1000},
            '{KIND_SET,   32'd5000,      16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b1, 32'd5000},
            '{KIND_CLEAR, 32'hA5A5_A5A5, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h5A5A_5A5A, 16'd1,     1'b1, 32'd0},
            '{KIND_SET,   32'd123456789, 16'd1,     1'b0, 32'd0},
            '{KIND_TICK,  32'h0000_0000, 16'd7,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b0, 32'd0},
            '{KIND_READ,  32'h0000_0000, 16'd1,     1'b0, 32'd0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            repeat (script[i].reps)
                send_txn(script[i].kind, script[i].ms, script[i].typed, script[i].want);
        end

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            idle_on = (items_sent - start_count < RANDOM_ITEMS - QUIET_TAIL)
                      && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 3))
                    0: ms = $urandom();
                    1: ms = $urandom_range(0, 4294966) * 32'd1000 + $urandom_range(960, 999);
                    2: ms = $urandom_range(0, 4294966) * 32'd1000 + $urandom_range(0, 40);
                    default: ms = $urandom_range(0, 50000);
                endcase
                send_txn(KIND_SET, ms, 1'b0, '0);
                repeat ($urandom_range(1, 4)) read_burst($urandom_range(0, 48));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_txn(KIND_W'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
            end
        end
        idle_on = 1'b0;
        req_bus.valid <= 1'b0;

        while (expected_ts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
